FILE: hdl/ict_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ict_pkg
// Shared types and constants for the INVITE client transaction state machine.
// ----------------------------------------------------------------------------
package ict_pkg;

    // Timer fields and interval registers share this width.
    localparam int TimerWidth = 20;
    localparam int CfgWidth   = 20;
    localparam int CfgIdxW    = 2;

    // Status code class boundaries.
    localparam logic [9:0] CodeProvLo = 10'd100;
    localparam logic [9:0] CodeOkLo   = 10'd200;
    localparam logic [9:0] CodeFailLo = 10'd300;
    localparam logic [9:0] CodeFailHi = 10'd699;

    // Reset values of the configuration registers.
    localparam logic [TimerWidth-1:0] RetransmitInitReset = TimerWidth'(500);
    localparam logic [TimerWidth-1:0] TimeoutReset        = TimerWidth'(32000);
    localparam logic [TimerWidth-1:0] LingerReset         = TimerWidth'(32000);

    typedef enum logic [2:0] {
        ST_START      = 3'd0,
        ST_CALLING    = 3'd1,
        ST_PROCEEDING = 3'd2,
        ST_COMPLETED  = 3'd3,
        ST_TERMINATED = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        EV_INVITE   = 3'd0,
        EV_RESPONSE = 3'd1,
        EV_TIMER_A  = 3'd2,
        EV_TIMER_B  = 3'd3,
        EV_TIMER_D  = 3'd4,
        EV_TERR     = 3'd5,
        EV_INTERR   = 3'd6,
        EV_CANCEL   = 3'd7
    } event_t;

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_PROV = 2'd1,
        CLS_OK   = 2'd2,
        CLS_FAIL = 2'd3
    } status_class_t;

    typedef enum logic [1:0] {
        SEND_NONE    = 2'd0,
        SEND_INVITE  = 2'd1,
        SEND_RESEND  = 2'd2,
        SEND_INV_ACK = 2'd3
    } send_kind_t;

    typedef enum logic [1:0] {
        UP_NONE     = 2'd0,
        UP_RESPONSE = 2'd1,
        UP_TERR     = 2'd2
    } upward_kind_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_RETRANSMIT_INIT = 2'd0,
        CFG_TIMEOUT         = 2'd1,
        CFG_LINGER          = 2'd2,
        CFG_UNRELIABLE      = 2'd3
    } cfg_index_t;

    // Configuration register contents.
    typedef struct packed {
        logic [TimerWidth-1:0] retransmit_initial_ticks;
        logic [TimerWidth-1:0] transaction_timeout_ticks;
        logic [TimerWidth-1:0] linger_ticks;
        logic                  unreliable_transport;
    } cfg_t;

    // One result beat.
    typedef struct packed {
        logic                  matched;
        logic [2:0]            next_state;
        logic [1:0]            send_kind;
        logic [1:0]            upward_kind;
        logic                  report_terminated;
        logic                  arm_retransmit;
        logic [TimerWidth-1:0] retransmit_ticks;
        logic                  arm_timeout;
        logic                  arm_linger;
        logic [TimerWidth-1:0] linger_duration;
        logic                  cancel_a_b;
        logic                  cancel_linger;
    } rsp_t;

    // Map a response status code onto its class.
    function automatic status_class_t status_class(input logic [9:0] code);
        status_class_t cls;
        if (code < CodeProvLo || code > CodeFailHi) begin
            cls = CLS_NONE;
        end else if (code < CodeOkLo) begin
            cls = CLS_PROV;
        end else if (code < CodeFailLo) begin
            cls = CLS_OK;
        end else begin
            cls = CLS_FAIL;
        end
        return cls;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/ict_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ict_req_if
// Event channel: one beat carries one transaction event.
// ----------------------------------------------------------------------------
interface ict_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [9:0] status_code;

    modport source (output valid, output req_type, output status_code, input ready);
    modport sink   (input valid, input req_type, input status_code, output ready);
endinterface
`default_nettype wire

FILE: hdl/ict_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ict_rsp_if
// Result channel: one beat carries the transition outcome and its actions.
// ----------------------------------------------------------------------------
interface ict_rsp_if;
    import ict_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  matched;
    logic [2:0]            next_state;
    logic [1:0]            send_kind;
    logic [1:0]            upward_kind;
    logic                  report_terminated;
    logic                  arm_retransmit;
    logic [TimerWidth-1:0] retransmit_ticks;
    logic                  arm_timeout;
    logic                  arm_linger;
    logic [TimerWidth-1:0] linger_duration;
    logic                  cancel_a_b;
    logic                  cancel_linger;

    modport source (
        output valid, output matched, output next_state, output send_kind,
        output upward_kind, output report_terminated, output arm_retransmit,
        output retransmit_ticks, output arm_timeout, output arm_linger,
        output linger_duration, output cancel_a_b, output cancel_linger,
        input  ready
    );
    modport sink (
        input  valid, input matched, input next_state, input send_kind,
        input  upward_kind, input report_terminated, input arm_retransmit,
        input  retransmit_ticks, input arm_timeout, input arm_linger,
        input  linger_duration, input cancel_a_b, input cancel_linger,
        output ready
    );
endinterface
`default_nettype wire

FILE: hdl/ict_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ict_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module ict_cfg_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire logic [ict_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [ict_pkg::CfgWidth-1:0] cfg_wdata,
    output ict_pkg::cfg_t                    cfg
);
    import ict_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed register.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_RETRANSMIT_INIT: cfg_next.retransmit_initial_ticks = cfg_wdata;
                CFG_TIMEOUT:         cfg_next.transaction_timeout_ticks = cfg_wdata;
                CFG_LINGER:          cfg_next.linger_ticks = cfg_wdata;
                CFG_UNRELIABLE:      cfg_next.unreliable_transport = cfg_wdata[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.retransmit_initial_ticks  <= RetransmitInitReset;
            cfg_reg.transaction_timeout_ticks <= TimeoutReset;
            cfg_reg.linger_ticks              <= LingerReset;
            cfg_reg.unreliable_transport      <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule
`default_nettype wire

FILE: hdl/ict_decide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ict_decide
// Transition logic: picks the transition for one event in the current phase
// and forms the new phase, the new retransmit interval and the actions.
// ----------------------------------------------------------------------------
module ict_decide (
    input  ict_pkg::phase_t                     phase,
    input  wire logic [ict_pkg::TimerWidth-1:0] interval,
    input  ict_pkg::cfg_t                       cfg,
    input  wire logic [2:0]                     req_type,
    input  wire logic [9:0]                     status_code,
    output ict_pkg::phase_t                     phase_next,
    output logic [ict_pkg::TimerWidth-1:0]      interval_next,
    output ict_pkg::rsp_t                       rsp
);
    import ict_pkg::*;

    localparam logic [TimerWidth-1:0] TimerMax = '1;

    event_t                ev;
    status_class_t         cls;
    logic                  unrel;
    logic [TimerWidth-1:0] doubled;

    assign ev    = event_t'(req_type);
    assign cls   = status_class(status_code);
    assign unrel = cfg.unreliable_transport;

    // Doubling saturates once the top bit would shift out.
    assign doubled = interval[TimerWidth-1] ? TimerMax : {interval[TimerWidth-2:0], 1'b0};

    always_comb
    begin
        rsp           = '0;
        phase_next    = phase;
        interval_next = interval;

        if (ev == EV_CANCEL)
        begin
            // Cancel always ends the transaction with no action.
            rsp.matched = 1'b1;
            phase_next  = ST_TERMINATED;
        end
        else
        begin
            unique case (phase)
                ST_START:
                begin
                    if (ev == EV_INVITE)
                    begin
                        rsp.matched     = 1'b1;
                        phase_next      = ST_CALLING;
                        rsp.arm_timeout = 1'b1;
                        rsp.send_kind   = SEND_INVITE;
                        if (unrel)
                        begin
                            interval_next        = cfg.retransmit_initial_ticks;
                            rsp.arm_retransmit   = 1'b1;
                            rsp.retransmit_ticks = cfg.retransmit_initial_ticks;
                        end
                    end
                end
                ST_CALLING, ST_PROCEEDING:
                begin
                    if (phase == ST_CALLING && ev == EV_TIMER_A)
                    begin
                        interval_next        = doubled;
                        rsp.matched          = 1'b1;
                        rsp.arm_retransmit   = 1'b1;
                        rsp.retransmit_ticks = doubled;
                        rsp.send_kind        = SEND_RESEND;
                    end
                    else if (ev == EV_RESPONSE && cls == CLS_PROV)
                    begin
                        rsp.matched     = 1'b1;
                        phase_next      = ST_PROCEEDING;
                        rsp.upward_kind = UP_RESPONSE;
                        rsp.cancel_a_b  = (phase == ST_CALLING);
                    end
                    else if (ev == EV_RESPONSE && cls == CLS_FAIL)
                    begin
                        rsp.matched         = 1'b1;
                        phase_next          = ST_COMPLETED;
                        rsp.cancel_a_b      = 1'b1;
                        rsp.arm_linger      = 1'b1;
                        rsp.linger_duration = unrel ? cfg.linger_ticks : '0;
                        rsp.upward_kind     = UP_RESPONSE;
                        rsp.send_kind       = SEND_INV_ACK;
                    end
                    else if (ev == EV_RESPONSE && cls == CLS_OK)
                    begin
                        rsp.matched           = 1'b1;
                        phase_next            = ST_TERMINATED;
                        rsp.cancel_a_b        = 1'b1;
                        rsp.upward_kind       = UP_RESPONSE;
                        rsp.report_terminated = 1'b1;
                    end
                    else if (phase == ST_CALLING && (ev == EV_TERR || ev == EV_TIMER_B))
                    begin
                        rsp.matched           = 1'b1;
                        phase_next            = ST_TERMINATED;
                        rsp.cancel_a_b        = 1'b1;
                        rsp.upward_kind       = UP_TERR;
                        rsp.report_terminated = 1'b1;
                    end
                end
                ST_COMPLETED:
                begin
                    if (ev == EV_RESPONSE && cls == CLS_FAIL)
                    begin
                        // Retransmitted final response: ACK it again.
                        rsp.matched   = 1'b1;
                        rsp.send_kind = SEND_INV_ACK;
                    end
                    else if (ev == EV_TERR)
                    begin
                        rsp.matched           = 1'b1;
                        phase_next            = ST_TERMINATED;
                        rsp.cancel_linger     = 1'b1;
                        rsp.upward_kind       = UP_TERR;
                        rsp.report_terminated = 1'b1;
                    end
                    else if (ev == EV_TIMER_D)
                    begin
                        rsp.matched           = 1'b1;
                        phase_next            = ST_TERMINATED;
                        rsp.report_terminated = 1'b1;
                    end
                end
                default:
                begin
                    // Terminated: only cancel fires, handled above.
                    phase_next = phase;
                end
            endcase
        end

        rsp.next_state = phase_next;
    end
endmodule
`default_nettype wire

FILE: hdl/invite_client_transaction_fsm_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// invite_client_transaction_fsm_unit
// INVITE client transaction state machine with registered event input and
// registered result output.
// ----------------------------------------------------------------------------
// The block takes one event beat per clock cycle and returns exactly one result
// beat per event, in order. An accepted event lands in an input register; once
// the result register is free or draining, the transition logic evaluates it
// against the phase and retransmit interval registers and writes the result
// register, updating both state registers in the same edge. The sustained rate
// is one event per cycle as long as the result side takes beats; a stalled
// result holds its register and the input register, after which the event port
// drops ready. Configuration writes take effect on the next cycle and are
// expected while no event is in flight.
module invite_client_transaction_fsm_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    ict_req_if.sink                           req,
    ict_rsp_if.source                         rsp,
    input  wire logic                         cfg_wr_en,
    input  wire logic [ict_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [ict_pkg::CfgWidth-1:0] cfg_wdata
);
    import ict_pkg::*;

    cfg_t                  cfg;
    logic                  in_valid_reg;
    logic [2:0]            req_type_reg;
    logic [9:0]            status_code_reg;
    logic                  out_valid_reg;
    rsp_t                  rsp_reg;
    rsp_t                  rsp_next;
    phase_t                phase_reg;
    phase_t                phase_next;
    logic [TimerWidth-1:0] interval_reg;
    logic [TimerWidth-1:0] interval_next;
    logic                  advance;
    logic                  take;

    ict_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ict_decide u_decide (
        .phase         (phase_reg),
        .interval      (interval_reg),
        .cfg           (cfg),
        .req_type      (req_type_reg),
        .status_code   (status_code_reg),
        .phase_next    (phase_next),
        .interval_next (interval_next),
        .rsp           (rsp_next)
    );

    // The held event moves on when the result register is free or draining.
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign take      = req.valid && req.ready;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            req_type_reg    <= req.req_type;
            status_code_reg <= req.status_code;
        end
    end

    // Transaction state, updated as each event is resolved.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= ST_START;
            interval_reg <= RetransmitInitReset;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            interval_reg <= interval_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Drive the result channel.
    assign rsp.valid             = out_valid_reg;
    assign rsp.matched           = rsp_reg.matched;
    assign rsp.next_state        = rsp_reg.next_state;
    assign rsp.send_kind         = rsp_reg.send_kind;
    assign rsp.upward_kind       = rsp_reg.upward_kind;
    assign rsp.report_terminated = rsp_reg.report_terminated;
    assign rsp.arm_retransmit    = rsp_reg.arm_retransmit;
    assign rsp.retransmit_ticks  = rsp_reg.retransmit_ticks;
    assign rsp.arm_timeout       = rsp_reg.arm_timeout;
    assign rsp.arm_linger        = rsp_reg.arm_linger;
    assign rsp.linger_duration   = rsp_reg.linger_duration;
    assign rsp.cancel_a_b        = rsp_reg.cancel_a_b;
    assign rsp.cancel_linger     = rsp_reg.cancel_linger;
endmodule
`default_nettype wire

FILE: dv/tb_invite_client_transaction_fsm_unit.sv
// ----------------------------------------------------------------------------
// tb_invite_client_transaction_fsm_unit
// Self-checking bench for the INVITE client transaction state machine. A
// short table walks the start state, the INVITE and the early calling state,
// including register writes while calling. A state-aware random generator
// then carries the transaction through its remaining states. Every event beat
// is run through a local transition model, and every result beat is compared
// field by field with the oldest outstanding prediction. Both channels idle
// at random, and the idling changes from one burst to the next.
// ----------------------------------------------------------------------------
module tb_invite_client_transaction_fsm_unit;
    import ict_pkg::*;

    localparam int WatchdogLimit = 1000;
    localparam int TargetEvents  = 1000;
    localparam int DrainCycles   = 4;

    typedef enum {ROW_EVENT, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t             kind;
        event_t                ev;
        logic [9:0]            code;
        cfg_index_t            idx;
        logic [CfgWidth-1:0]   value;
        bit                    typed;
        rsp_t                  want;
    } row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgWidth-1:0] cfg_wdata;

    ict_req_if req_ch ();
    ict_rsp_if rsp_ch ();

    invite_client_transaction_fsm_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Local copy of the transaction state and registers.
    phase_t                model_phase;
    logic [TimerWidth-1:0] model_interval;
    cfg_t                  model_cfg;

    rsp_t        pending_results[$];
    row_t        directed_rows[$];
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned error_count;
    int unsigned results_checked;
    int unsigned quiet_cycles;
    bit [4:0]    phases_seen;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Result for an event that fires nothing: only the phase is reported.
    function automatic rsp_t quiet_result(input phase_t st);
        rsp_t r;
        r = '0;
        r.next_state = st;
        return r;
    endfunction

    // Advance the local transaction model by one event and return its result.
    function automatic rsp_t advance_transaction(input event_t ev, input logic [9:0] code);
        rsp_t                r;
        phase_t              nxt;
        logic [TimerWidth:0] doubled;
        bit                  prov;
        bit                  ok;
        bit                  fail;
        bit                  calling;
        r       = '0;
        nxt     = model_phase;
        prov    = (code >= CodeProvLo) && (code < CodeOkLo);
        ok      = (code >= CodeOkLo) && (code < CodeFailLo);
        fail    = (code >= CodeFailLo) && (code <= CodeFailHi);
        calling = (model_phase == ST_CALLING);
        if (ev == EV_CANCEL)
        begin
            r.matched = 1'b1;
            nxt       = ST_TERMINATED;
        end
        else
        begin
            case (model_phase)
                ST_START:
                begin
                    if (ev == EV_INVITE)
                    begin
                        r.matched     = 1'b1;
                        nxt           = ST_CALLING;
                        r.send_kind   = SEND_INVITE;
                        r.arm_timeout = 1'b1;
                        // Datagram transport reloads the interval and arms timer A.
                        if (model_cfg.unreliable_transport)
                        begin
                            model_interval     = model_cfg.retransmit_initial_ticks;
                            r.arm_retransmit   = 1'b1;
                            r.retransmit_ticks = model_interval;
                        end
                    end
                end
                ST_CALLING, ST_PROCEEDING:
                begin
                    if (calling && ev == EV_TIMER_A)
                    begin
                        // Double the interval, saturating at the all-ones value.
                        doubled = {model_interval, 1'b0};
                        model_interval = doubled[TimerWidth] ? '1 : doubled[TimerWidth-1:0];
                        r.matched          = 1'b1;
                        r.arm_retransmit   = 1'b1;
                        r.retransmit_ticks = model_interval;
                        r.send_kind        = SEND_RESEND;
                    end
                    else if (ev == EV_RESPONSE && prov)
                    begin
                        r.matched     = 1'b1;
                        nxt           = ST_PROCEEDING;
                        r.upward_kind = UP_RESPONSE;
                        r.cancel_a_b  = calling;
                    end
                    else if (ev == EV_RESPONSE && fail)
                    begin
                        r.matched         = 1'b1;
                        nxt               = ST_COMPLETED;
                        r.cancel_a_b      = 1'b1;
                        r.arm_linger      = 1'b1;
                        r.linger_duration = model_cfg.unreliable_transport ?
                                            model_cfg.linger_ticks : '0;
                        r.upward_kind     = UP_RESPONSE;
                        r.send_kind       = SEND_INV_ACK;
                    end
                    else if (ev == EV_RESPONSE && ok)
                    begin
                        r.matched           = 1'b1;
                        nxt                 = ST_TERMINATED;
                        r.cancel_a_b        = 1'b1;
                        r.upward_kind       = UP_RESPONSE;
                        r.report_terminated = 1'b1;
                    end
                    else if (calling && (ev == EV_TERR || ev == EV_TIMER_B))
                    begin
                        r.matched           = 1'b1;
                        nxt                 = ST_TERMINATED;
                        r.cancel_a_b        = 1'b1;
                        r.upward_kind       = UP_TERR;
                        r.report_terminated = 1'b1;
                    end
                end
                ST_COMPLETED:
                begin
                    if (ev == EV_RESPONSE && fail)
                    begin
                        r.matched   = 1'b1;
                        r.send_kind = SEND_INV_ACK;
                    end
                    else if (ev == EV_TERR)
                    begin
                        r.matched           = 1'b1;
                        nxt                 = ST_TERMINATED;
                        r.cancel_linger     = 1'b1;
                        r.upward_kind       = UP_TERR;
                        r.report_terminated = 1'b1;
                    end
                    else if (ev == EV_TIMER_D)
                    begin
                        r.matched           = 1'b1;
                        nxt                 = ST_TERMINATED;
                        r.report_terminated = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        model_phase  = nxt;
        r.next_state = nxt;
        return r;
    endfunction

    // Pick the next event from the current phase: mostly events that keep the
    // transaction alive, now and then one that moves it on, plus some noise.
    function automatic void pick_event(output event_t ev, output logic [9:0] code);
        bit          live;
        bit          leave;
        int unsigned roll;
        live  = (model_phase != ST_START) && (model_phase != ST_TERMINATED);
        code  = 10'($urandom_range(1023));
        ev    = EV_CANCEL;
        if ($urandom_range(99) < (live ? 3 : 30))
        begin
            ev = event_t'($urandom_range(int'(EV_INTERR)));
            return;
        end
        leave = ($urandom_range(149) == 0);
        roll  = $urandom_range(99);
        case (model_phase)
            ST_START:
            begin
                ev = EV_INVITE;
            end
            ST_CALLING:
            begin
                if (!leave)
                begin
                    if (roll < 80)
                    begin
                        ev = EV_TIMER_A;
                    end
                    else
                    begin
                        // Responses whose code belongs to no class.
                        ev   = EV_RESPONSE;
                        code = $urandom_range(1) ? 10'($urandom_range(99)) :
                                                   10'($urandom_range(1023, 700));
                    end
                end
                else if (roll < 40)
                begin
                    ev   = EV_RESPONSE;
                    code = 10'($urandom_range(199, 100));
                end
                else if (roll < 70)
                begin
                    ev   = EV_RESPONSE;
                    code = 10'($urandom_range(699, 300));
                end
                else if (roll < 80)
                begin
                    ev   = EV_RESPONSE;
                    code = 10'($urandom_range(299, 200));
                end
                else if (roll < 88)
                begin
                    ev = EV_TERR;
                end
                else if (roll < 95)
                begin
                    ev = EV_TIMER_B;
                end
            end
            ST_PROCEEDING:
            begin
                ev = EV_RESPONSE;
                if (!leave)
                begin
                    code = 10'($urandom_range(199, 100));
                end
                else if (roll < 70)
                begin
                    code = 10'($urandom_range(699, 300));
                end
                else if (roll < 90)
                begin
                    code = 10'($urandom_range(299, 200));
                end
                else
                begin
                    ev = EV_CANCEL;
                end
            end
            ST_COMPLETED:
            begin
                if (!leave)
                begin
                    ev   = EV_RESPONSE;
                    code = 10'($urandom_range(699, 300));
                end
                else if (roll < 50)
                begin
                    ev = EV_TIMER_D;
                end
                else if (roll < 90)
                begin
                    ev = EV_TERR;
                end
            end
            default:
            begin
                ev = EV_CANCEL;
            end
        endcase
    endfunction

    function automatic void add_event(input event_t ev, input logic [9:0] code,
                                      input bit typed, input rsp_t want);
        row_t row;
        row.kind  = ROW_EVENT;
        row.ev    = ev;
        row.code  = code;
        row.idx   = CFG_RETRANSMIT_INIT;
        row.value = '0;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_write(input cfg_index_t idx, input logic [CfgWidth-1:0] value);
        row_t row;
        row.kind  = ROW_WRITE;
        row.ev    = EV_INTERR;
        row.code  = '0;
        row.idx   = idx;
        row.value = value;
        row.typed = 1'b0;
        row.want  = '0;
        directed_rows.push_back(row);
    endfunction

    // Directed table: start-state events that fire nothing, the INVITE under
    // reset registers, then calling with out-of-class codes, timer A, a switch
    // to reliable transport and a reload value that must not touch the interval.
    function automatic void load_directed_rows();
        rsp_t invite_rsp;
        invite_rsp                  = '0;
        invite_rsp.matched          = 1'b1;
        invite_rsp.next_state       = ST_CALLING;
        invite_rsp.send_kind        = SEND_INVITE;
        invite_rsp.arm_retransmit   = 1'b1;
        invite_rsp.retransmit_ticks = RetransmitInitReset;
        invite_rsp.arm_timeout      = 1'b1;
        add_event(EV_INTERR,   10'd0,    1'b1, quiet_result(ST_START));
        add_event(EV_RESPONSE, 10'd0,    1'b1, quiet_result(ST_START));
        add_event(EV_RESPONSE, 10'd1023, 1'b1, quiet_result(ST_START));
        add_event(EV_RESPONSE, 10'd150,  1'b1, quiet_result(ST_START));
        add_event(EV_TIMER_A,  10'd512,  1'b1, quiet_result(ST_START));
        add_event(EV_TIMER_B,  10'd0,    1'b1, quiet_result(ST_START));
        add_event(EV_TIMER_D,  10'd699,  1'b1, quiet_result(ST_START));
        add_event(EV_TERR,     10'd200,  1'b1, quiet_result(ST_START));
        add_event(EV_INVITE,   10'd0,    1'b1, invite_rsp);
        add_event(EV_RESPONSE, 10'd99,   1'b1, quiet_result(ST_CALLING));
        add_event(EV_RESPONSE, 10'd700,  1'b1, quiet_result(ST_CALLING));
        add_event(EV_INVITE,   10'd1023, 1'b1, quiet_result(ST_CALLING));
        add_event(EV_TIMER_D,  10'd0,    1'b1, quiet_result(ST_CALLING));
        add_event(EV_INTERR,   10'd300,  1'b1, quiet_result(ST_CALLING));
        add_event(EV_TIMER_A,  10'd0,    1'b0, '0);
        add_write(CFG_UNRELIABLE, '0);
        add_event(EV_TIMER_A,  10'd0,    1'b0, '0);
        add_write(CFG_RETRANSMIT_INIT, '1);
        add_event(EV_TIMER_A,  10'd1023, 1'b0, '0);
    endfunction

    // Drive one event beat after a random idle stretch; called at a rising edge
    // and returns at the edge that accepts the beat.
    task automatic send_event(input event_t ev, input logic [9:0] code, input bit typed,
                              input rsp_t want, output bit fired);
        bit   taken;
        rsp_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= ev;
        req_ch.status_code <= code;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = req_ch.ready;
            @(posedge clk);
        end
        predicted = advance_transaction(ev, code);
        phases_seen[model_phase] = 1'b1;
        pending_results.push_back(typed ? want : predicted);
        fired = predicted.matched;
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [CfgWidth-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        case (idx)
            CFG_RETRANSMIT_INIT: model_cfg.retransmit_initial_ticks  = value;
            CFG_TIMEOUT:         model_cfg.transaction_timeout_ticks = value;
            CFG_LINGER:          model_cfg.linger_ticks              = value;
            default:             model_cfg.unreliable_transport      = value[0];
        endcase
    endtask

    task automatic settle_registers();
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    // Stimulus and end of run.
    initial
    begin : stimulus
        int unsigned         events_sent;
        int unsigned         fired_total;
        int unsigned         phase_idx;
        int unsigned         burst;
        bit                  fired;
        event_t              ev;
        logic [9:0]          code;
        cfg_index_t          idx;
        logic [CfgWidth-1:0] lo;
        logic [CfgWidth-1:0] hi;
        logic [CfgWidth-1:0] value;

        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= EV_INTERR;
        req_ch.status_code <= '0;
        cfg_wr_en          <= 1'b0;
        cfg_index          <= CFG_RETRANSMIT_INIT;
        cfg_wdata          <= '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        error_count     = 0;
        results_checked = 0;
        phases_seen     = '0;
        events_sent     = 0;
        fired_total     = 0;
        model_phase     = ST_START;
        model_interval  = RetransmitInitReset;
        model_cfg.retransmit_initial_ticks  = RetransmitInitReset;
        model_cfg.transaction_timeout_ticks = TimeoutReset;
        model_cfg.linger_ticks              = LingerReset;
        model_cfg.unreliable_transport      = 1'b1;
        phases_seen[ST_START] = 1'b1;
        load_directed_rows();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                drain_results();
                write_register(directed_rows[i].idx, directed_rows[i].value);
                settle_registers();
            end
            else
            begin
                send_event(directed_rows[i].ev, directed_rows[i].code,
                           directed_rows[i].typed, directed_rows[i].want, fired);
                events_sent++;
            end
        end

        // Random bursts, each under its own register setting and idling mode.
        phase_idx = 0;
        while (events_sent < TargetEvents)
        begin
            drain_results();
            idx = cfg_index_t'(phase_idx % 4);
            lo  = (idx == CFG_LINGER || idx == CFG_UNRELIABLE) ? '0 : CfgWidth'(1);
            hi  = (idx == CFG_UNRELIABLE) ? CfgWidth'(1) : '1;
            case ($urandom_range(3))
                0:       value = lo;
                1:       value = hi;
                default: value = CfgWidth'($urandom_range(hi, lo));
            endcase
            write_register(idx, value);
            settle_registers();
            case (phase_idx % 5)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 72;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 72;
                end
                3:
                begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
                default:
                begin
                    send_idle_pct  = $urandom_range(80);
                    recv_stall_pct = $urandom_range(80);
                end
            endcase
            burst = $urandom_range(120, 30);
            repeat (burst)
            begin
                pick_event(ev, code);
                send_event(ev, code, 1'b0, '0, fired);
                events_sent++;
                fired_total += fired;
            end
            phase_idx++;
        end

        drain_results();
        repeat (2 * DrainCycles) @(posedge clk);

        $display("Sent %0d events (%0d fired in the random part) over %0d bursts.",
                 events_sent, fired_total, phase_idx);
        $display("Checked %0d result beats; phases reached %b, ending in %s.",
                 results_checked, phases_seen, model_phase.name());
        if (error_count == 0)
        begin
            $display("invite_client_transaction_fsm_unit regression: pass");
        end
        else
        begin
            $display("invite_client_transaction_fsm_unit regression: fail");
        end
        $finish;
    end

    // Result side: random backpressure, updated at every rising edge.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void check_field(input string name, input logic [TimerWidth-1:0] want,
                                        input logic [TimerWidth-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Result beats are sampled at the falling edge before the edge that takes them.
    always @(negedge clk)
    begin : result_monitor
        rsp_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with no event outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("matched",           want.matched,           rsp_ch.matched);
                check_field("next_state",        want.next_state,        rsp_ch.next_state);
                check_field("send_kind",         want.send_kind,         rsp_ch.send_kind);
                check_field("upward_kind",       want.upward_kind,       rsp_ch.upward_kind);
                check_field("report_terminated", want.report_terminated,
                            rsp_ch.report_terminated);
                check_field("arm_retransmit",    want.arm_retransmit,    rsp_ch.arm_retransmit);
                check_field("retransmit_ticks",  want.retransmit_ticks,  rsp_ch.retransmit_ticks);
                check_field("arm_timeout",       want.arm_timeout,       rsp_ch.arm_timeout);
                check_field("arm_linger",        want.arm_linger,        rsp_ch.arm_linger);
                check_field("linger_duration",   want.linger_duration,   rsp_ch.linger_duration);
                check_field("cancel_a_b",        want.cancel_a_b,        rsp_ch.cancel_a_b);
                check_field("cancel_linger",     want.cancel_linger,     rsp_ch.cancel_linger);
            end
        end
    end

    // Watchdog: too many cycles in a row without a beat on either channel.
    always @(negedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WatchdogLimit)
            begin
                $display("Timed out with %0d results outstanding.", pending_results.size());
                $display("invite_client_transaction_fsm_unit regression: fail");
                $finish;
            end
        end
    end

endmodule
